// ----- hdl/phtc_pkg.sv -----
package phtc_pkg;

  localparam int unsigned DefTableSlots  = 64;
  localparam int unsigned DefCounterBits = 32;
  localparam int unsigned AddrW          = 32;
  localparam int unsigned LenW           = 16;
  localparam int unsigned SlotW          = 6;
  localparam int unsigned WordW          = 32;

  localparam logic OpAccount = 1'b0;
  localparam logic OpRead    = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [AddrW-1:0]  src;
    logic [AddrW-1:0]  dst;
    logic [LenW-1:0]   len;
    logic [SlotW-1:0]  rslot;
    logic              src_pend;
    logic              dst_pend;
    logic [SlotW-1:0]  src_slot;
    logic [SlotW-1:0]  dst_slot;
    logic              rd_valid;
    logic [AddrW-1:0]  rd_addr;
    logic [WordW-1:0]  rd_sent_pkts;
    logic [WordW-1:0]  rd_sent_bytes;
    logic [WordW-1:0]  rd_recv_pkts;
    logic [WordW-1:0]  rd_recv_bytes;
  } token_t;

endpackage

// ----- hdl/phtc_cell.sv -----
module phtc_cell #(
  parameter int unsigned IDX          = 0,
  parameter int unsigned COUNTER_BITS = phtc_pkg::DefCounterBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  phtc_pkg::token_t  tok_i,
  output phtc_pkg::token_t  tok_o
);
  import phtc_pkg::*;

  localparam logic [SlotW-1:0] MySlot = SlotW'(IDX);
  localparam bit Readable = (IDX < (1 << SlotW));

  logic                    used_q, used_d;
  logic [AddrW-1:0]        addr_q, addr_d;
  logic [COUNTER_BITS-1:0] sp_q, sp_d, sb_q, sb_d, rp_q, rp_d, rb_q, rb_d;
  token_t                  tok_q, tok_d;
  logic                    acct, src_hit, dst_hit, alloc_src, alloc_dst;
  logic [COUNTER_BITS-1:0] len_ext;

  always_comb begin
    tok_d     = tok_i;
    used_d    = used_q;
    addr_d    = addr_q;
    sp_d      = sp_q;
    sb_d      = sb_q;
    rp_d      = rp_q;
    rb_d      = rb_q;
    len_ext   = COUNTER_BITS'(tok_i.len);
    acct      = tok_i.valid && (tok_i.op == OpAccount);
    src_hit   = acct && used_q && tok_i.src_pend && (addr_q == tok_i.src);
    dst_hit   = acct && used_q && tok_i.dst_pend && (addr_q == tok_i.dst);
    alloc_src = acct && !used_q && tok_i.src_pend;
    alloc_dst = acct && !used_q && tok_i.dst_pend &&
                (!tok_i.src_pend || (tok_i.dst == tok_i.src));
    if (src_hit) begin
      sp_d           = sp_q + COUNTER_BITS'(1);
      sb_d           = sb_q + len_ext;
      tok_d.src_pend = 1'b0;
      tok_d.src_slot = MySlot;
    end
    if (dst_hit) begin
      rp_d           = rp_q + COUNTER_BITS'(1);
      rb_d           = rb_q + len_ext;
      tok_d.dst_pend = 1'b0;
      tok_d.dst_slot = MySlot;
    end
    if (alloc_src || alloc_dst) begin
      used_d = 1'b1;
      addr_d = alloc_src ? tok_i.src : tok_i.dst;
      sp_d   = alloc_src ? COUNTER_BITS'(1) : '0;
      sb_d   = alloc_src ? len_ext : '0;
      rp_d   = alloc_dst ? COUNTER_BITS'(1) : '0;
      rb_d   = alloc_dst ? len_ext : '0;
    end
    if (alloc_src) begin
      tok_d.src_pend = 1'b0;
      tok_d.src_slot = MySlot;
    end
    if (alloc_dst) begin
      tok_d.dst_pend = 1'b0;
      tok_d.dst_slot = MySlot;
    end
    if (Readable && tok_i.valid && (tok_i.op == OpRead) && used_q &&
        (tok_i.rslot == MySlot)) begin
      tok_d.rd_valid      = 1'b1;
      tok_d.rd_addr       = addr_q;
      tok_d.rd_sent_pkts  = WordW'(sp_q);
      tok_d.rd_sent_bytes = WordW'(sb_q);
      tok_d.rd_recv_pkts  = WordW'(rp_q);
      tok_d.rd_recv_bytes = WordW'(rb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    sp_q   <= sp_d;
    sb_q   <= sb_d;
    rp_q   <= rp_d;
    rb_q   <= rb_d;
  end

  assign tok_o = tok_q;

endmodule

// ----- hdl/per_host_traffic_counter_table.sv -----
// Channel | Handshake               | Payload
// in      | in_valid_i / in_stall_o   | operation, addresses, length, read slot
// out     | out_valid_o / out_stall_i | slots, full flag, total, slot contents
// A request walks the row of cells, one cell per cycle, and holds one cell per slot.
// The request is registered in every cell in turn and then in the result register; one
// request at a time, so a new request is taken only once the previous result is taken.
// Reset empties every slot at once and clears the packet total.
// in_stall_o is high from accept until the result is taken; out_stall_i holds it.
module per_host_traffic_counter_table #(
  parameter int unsigned TABLE_SLOTS  = phtc_pkg::DefTableSlots,
  parameter int unsigned COUNTER_BITS = phtc_pkg::DefCounterBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [phtc_pkg::AddrW-1:0]  source_address_i,
  input  logic [phtc_pkg::AddrW-1:0]  destination_address_i,
  input  logic [phtc_pkg::LenW-1:0]   packet_length_i,
  input  logic [phtc_pkg::SlotW-1:0]  read_slot_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [phtc_pkg::SlotW-1:0]  source_slot_o,
  output logic [phtc_pkg::SlotW-1:0]  destination_slot_o,
  output logic                        table_full_o,
  output logic [phtc_pkg::WordW-1:0]  total_packets_o,
  output logic                        entry_valid_o,
  output logic [phtc_pkg::AddrW-1:0]  entry_address_o,
  output logic [phtc_pkg::WordW-1:0]  sent_packets_o,
  output logic [phtc_pkg::WordW-1:0]  sent_bytes_o,
  output logic [phtc_pkg::WordW-1:0]  received_packets_o,
  output logic [phtc_pkg::WordW-1:0]  received_bytes_o
);
  import phtc_pkg::*;

  token_t             chain [TABLE_SLOTS+1];
  token_t             head;
  token_t             out_q;
  logic               busy_q, out_valid_q, in_acc, out_acc, acct;
  logic [WordW-1:0]   total_q;
  logic [TABLE_SLOTS:0] chain_valid;

  assign in_acc = in_valid_i && !busy_q;
  assign out_acc = out_valid_q && !out_stall_i;
  assign acct = operation_i == OpAccount;

  always_comb begin
    head          = '0;
    head.valid    = in_acc;
    head.op       = operation_i;
    head.src      = source_address_i;
    head.dst      = destination_address_i;
    head.len      = packet_length_i;
    head.rslot    = read_slot_i;
    head.src_pend = acct;
    head.dst_pend = acct;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    phtc_cell #(
      .IDX          (g),
      .COUNTER_BITS (COUNTER_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  for (genvar g = 0; g <= TABLE_SLOTS; g++) begin : g_vld
    assign chain_valid[g] = chain[g].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
        if (acct) begin
          total_q <= total_q + WordW'(1);
        end
      end else if (out_acc) begin
        busy_q <= 1'b0;
      end
      if (chain[TABLE_SLOTS].valid) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain[TABLE_SLOTS].valid) begin
      out_q <= chain[TABLE_SLOTS];
    end
  end

  assign in_stall_o         = busy_q;
  assign out_valid_o        = out_valid_q;
  assign source_slot_o      = out_q.src_pend ? '0 : out_q.src_slot;
  assign destination_slot_o = out_q.dst_pend ? '0 : out_q.dst_slot;
  assign table_full_o       = out_q.src_pend || out_q.dst_pend;
  assign total_packets_o    = total_q;
  assign entry_valid_o      = out_q.rd_valid;
  assign entry_address_o    = out_q.rd_addr;
  assign sent_packets_o     = out_q.rd_sent_pkts;
  assign sent_bytes_o       = out_q.rd_sent_bytes;
  assign received_packets_o = out_q.rd_recv_pkts;
  assign received_bytes_o   = out_q.rd_recv_bytes;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({chain_valid, out_valid_q})) else $error("more than one request in flight");
  a_out_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> busy_q) else $error("result without request");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && !out_valid_q) else $error("accept did not mark busy");
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.op == OpRead) |-> !table_full_o) else $error("full on read");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import phtc_pkg::*;

  localparam int unsigned Slots = DefTableSlots;
  localparam int unsigned CycleLimit = 1200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = OpAccount;
  logic [AddrW-1:0] source_address_i = '0;
  logic [AddrW-1:0] destination_address_i = '0;
  logic [LenW-1:0] packet_length_i = '0;
  logic [SlotW-1:0] read_slot_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SlotW-1:0] source_slot_o, destination_slot_o;
  logic table_full_o, entry_valid_o;
  logic [WordW-1:0] total_packets_o, sent_packets_o, sent_bytes_o;
  logic [WordW-1:0] received_packets_o, received_bytes_o;
  logic [AddrW-1:0] entry_address_o;

  typedef struct packed {
    logic [SlotW-1:0] src_slot;
    logic [SlotW-1:0] dst_slot;
    logic full;
    logic [WordW-1:0] total;
    logic ent_valid;
    logic [AddrW-1:0] ent_addr;
    logic [WordW-1:0] tx_pkts;
    logic [WordW-1:0] tx_bytes;
    logic [WordW-1:0] rx_pkts;
    logic [WordW-1:0] rx_bytes;
  } host_report_t;

  per_host_traffic_counter_table i_dut (.*);

  // shadow host table
  logic [AddrW-1:0] host_addr [Slots];
  logic host_used [Slots];
  logic [WordW-1:0] tx_pkts [Slots], tx_bytes [Slots], rx_pkts [Slots], rx_bytes [Slots];
  int unsigned hosts_known;
  logic [WordW-1:0] pkt_count;

  host_report_t expected_reports[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct, recv_idle_pct;
  bit hold_off;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int find_host(logic [AddrW-1:0] addr);
    for (int i = 0; i < Slots; i++) begin
      if (host_used[i] && host_addr[i] == addr) return i;
    end
    if (hosts_known >= Slots) return -1;
    host_used[hosts_known] = 1'b1;
    host_addr[hosts_known] = addr;
    tx_pkts[hosts_known] = '0;
    tx_bytes[hosts_known] = '0;
    rx_pkts[hosts_known] = '0;
    rx_bytes[hosts_known] = '0;
    hosts_known++;
    return int'(hosts_known) - 1;
  endfunction

  function automatic host_report_t predict_request(logic op, logic [AddrW-1:0] src,
      logic [AddrW-1:0] dst, logic [LenW-1:0] len, logic [SlotW-1:0] slot);
    host_report_t r;
    int s, d;
    r = '0;
    if (op == OpAccount) begin
      s = find_host(src);
      if (s >= 0) begin
        tx_pkts[s] += WordW'(1);
        tx_bytes[s] += WordW'(len);
        r.src_slot = s[SlotW-1:0];
      end else r.full = 1'b1;
      d = find_host(dst);
      if (d >= 0) begin
        rx_pkts[d] += WordW'(1);
        rx_bytes[d] += WordW'(len);
        r.dst_slot = d[SlotW-1:0];
      end else r.full = 1'b1;
      pkt_count += WordW'(1);
      r.total = pkt_count;
    end else begin
      r.total = pkt_count;
      if (slot < Slots && host_used[slot]) begin
        r.ent_valid = 1'b1;
        r.ent_addr = host_addr[slot];
        r.tx_pkts = tx_pkts[slot];
        r.tx_bytes = tx_bytes[slot];
        r.rx_pkts = rx_pkts[slot];
        r.rx_bytes = rx_bytes[slot];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_request(logic op, logic [AddrW-1:0] src, logic [AddrW-1:0] dst,
      logic [LenW-1:0] len, logic [SlotW-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    source_address_i <= src;
    destination_address_i <= dst;
    packet_length_i <= len;
    read_slot_i <= slot;
    expected_reports.push_back(predict_request(op, src, dst, len, slot));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    host_report_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) report_mismatch("unexpected result", '0, '0);
      else begin
        e = expected_reports.pop_front();
        if (source_slot_o !== e.src_slot)
          report_mismatch("source_slot", 64'(source_slot_o), 64'(e.src_slot));
        if (destination_slot_o !== e.dst_slot)
          report_mismatch("destination_slot", 64'(destination_slot_o), 64'(e.dst_slot));
        if (table_full_o !== e.full)
          report_mismatch("table_full", 64'(table_full_o), 64'(e.full));
        if (total_packets_o !== e.total)
          report_mismatch("total_packets", 64'(total_packets_o), 64'(e.total));
        if (entry_valid_o !== e.ent_valid)
          report_mismatch("entry_valid", 64'(entry_valid_o), 64'(e.ent_valid));
        if (entry_address_o !== e.ent_addr)
          report_mismatch("entry_address", 64'(entry_address_o), 64'(e.ent_addr));
        if (sent_packets_o !== e.tx_pkts)
          report_mismatch("sent_packets", 64'(sent_packets_o), 64'(e.tx_pkts));
        if (sent_bytes_o !== e.tx_bytes)
          report_mismatch("sent_bytes", 64'(sent_bytes_o), 64'(e.tx_bytes));
        if (received_packets_o !== e.rx_pkts)
          report_mismatch("received_packets", 64'(received_packets_o), 64'(e.rx_pkts));
        if (received_bytes_o !== e.rx_bytes)
          report_mismatch("received_bytes", 64'(received_bytes_o), 64'(e.rx_bytes));
      end
    end
  end

  task automatic wait_drained();
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  // pick an address, mostly from a small pool so lookups hit
  function automatic logic [AddrW-1:0] pick_host(int unsigned pool);
    if ($urandom_range(9) < 8) return 32'h0a00_0000 + $urandom_range(pool);
    return $urandom;
  endfunction

  task automatic test_directed();
    send_request(OpRead, 0, 0, 0, 0);
    send_request(OpAccount, 32'h0, 32'hffff_ffff, 16'hffff, 0);
    send_request(OpAccount, 32'hffff_ffff, 32'h0, 16'h0, 0);
    send_request(OpAccount, 32'hc0a8_0001, 32'hc0a8_0001, 16'h1234, 6'h3f);
    send_request(OpAccount, 32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 0);
    send_request(OpAccount, 32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 0);
    for (int i = 0; i < 6; i++)
      send_request(OpRead, $urandom, $urandom, LenW'($urandom), SlotW'(i));
    send_request(OpRead, 0, 0, 0, 6'h3f);
    send_request(OpRead, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 6'h2a);
  endtask

  task automatic test_random(int unsigned count, int unsigned pool);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        send_request(OpRead, $urandom, $urandom, LenW'($urandom), SlotW'($urandom));
      else send_request(OpAccount, pick_host(pool), pick_host(pool), LenW'($urandom),
          SlotW'($urandom));
    end
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(8, 20);
    join
    wait_drained();
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 70; i++)
      send_request(OpAccount, AddrW'(32'hc000_0000 + i), AddrW'(32'hd000_0000 + i),
          LenW'($urandom), 0);
    send_request(OpAccount, 32'h0a00_0001, 32'heeee_eeee, 16'hffff, 0);
    for (int i = 0; i < 64; i++) send_request(OpRead, 0, 0, 0, SlotW'(i));
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      host_used[i] = 1'b0;
      host_addr[i] = '0;
    end
    hosts_known = 0;
    pkt_count = '0;
    hold_off = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 55;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_random(300, 40);
    send_idle_pct = 55;
    recv_idle_pct = 36;
    test_back_pressure();
    test_random(300, 40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250, 60);
    test_table_full();
    test_random(100, 200);
    wait_drained();
    repeat (Slots + 10) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ----- per_host_traffic_counter_table.f -----
hdl/phtc_pkg.sv
hdl/phtc_cell.sv
hdl/per_host_traffic_counter_table.sv
tb/tb.sv
